[rtl/core/rpd_pkg.sv]
// Shared types, codes and constants for the response packet deframer.
// No dependencies; the register file, the engine, the deframer and the testbench refer to this package.
package rpd_pkg;

  // Request modes
  localparam logic [1:0] MODE_ARM  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // End-of-read status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_TIMEOUT   = 3'd1;
  localparam logic [2:0] STAT_BAD_START = 3'd2;
  localparam logic [2:0] STAT_BAD_ID    = 3'd3;
  localparam logic [2:0] STAT_BAD_SUM   = 3'd4;

  // Result kinds and packet kinds
  localparam logic RES_DATA = 1'b0;
  localparam logic RES_END  = 1'b1;
  localparam logic PKT_RESPONSE = 1'b0;
  localparam logic PKT_DATA     = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT        = 2'd3;

  // Configuration reset values
  localparam logic [15:0] RST_RESPONSE_START = 16'd21930;
  localparam logic [15:0] RST_DATA_START     = 16'd23205;
  localparam logic [15:0] RST_DEVICE_ID      = 16'd256;
  localparam logic [15:0] RST_TIMEOUT        = 16'd1000;

  localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;
  localparam logic [15:0] MIN_LENGTH    = 16'd6;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  byte_value;
    logic [15:0] expected_length;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        packet_kind;
    logic [31:0] parameter_word;
    logic [15:0] response_code;
  } result_t;

  typedef struct packed {
    logic [15:0] response_start_code;
    logic [15:0] data_start_code;
    logic [15:0] device_id_code;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

[rtl/core/rpd_in_if.sv]
// Input request channel of the deframer: valid/ready plus one item.
// Depends on nothing.
interface rpd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  byte_value;
  logic [15:0] expected_length;

  modport source(output valid, mode, byte_value, expected_length, input ready);
  modport sink(input valid, mode, byte_value, expected_length, output ready);
endinterface

[rtl/core/rpd_out_if.sv]
// Result channel of the deframer: valid/ready plus one result item.
// Depends on nothing.
interface rpd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic        packet_kind;
  logic [31:0] parameter_word;
  logic [15:0] response_code;

  modport source(output valid, result_kind, payload_byte, status, packet_kind,
                 parameter_word, response_code, input ready);
  modport sink(input valid, result_kind, payload_byte, status, packet_kind,
               parameter_word, response_code, output ready);
endinterface

[rtl/core/rpd_cfg_if.sv]
// Configuration write channel of the deframer: valid/ready, index, data.
// Depends on nothing.
interface rpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/rpd_cfg_regs.sv]
// Configuration register file of the deframer (start codes, id, timeout).
// Depends on rpd_pkg and rpd_cfg_if.
module rpd_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  rpd_cfg_if.sink        cfg,
  output rpd_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.response_start_code <= rpd_pkg::RST_RESPONSE_START;
      regs.data_start_code     <= rpd_pkg::RST_DATA_START;
      regs.device_id_code      <= rpd_pkg::RST_DEVICE_ID;
      regs.timeout_ticks       <= rpd_pkg::RST_TIMEOUT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rpd_pkg::CFG_RESPONSE_START: regs.response_start_code <= cfg.data;
        rpd_pkg::CFG_DATA_START:     regs.data_start_code     <= cfg.data;
        rpd_pkg::CFG_DEVICE_ID:      regs.device_id_code      <= cfg.data;
        rpd_pkg::CFG_TIMEOUT:        regs.timeout_ticks       <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/rpd_engine.sv]
// Per-request deframing engine: read state registers and the one-pass update
// that yields the next state and at most one result. Depends on rpd_pkg.
module rpd_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  rpd_pkg::item_t   item,
  input  rpd_pkg::cfg_t    regs,
  output logic             res_valid,
  output rpd_pkg::result_t res
);

  // Read state
  logic        armed, armed_next;
  logic [15:0] pos, pos_next;
  logic [15:0] len, len_next;
  logic [15:0] sum, sum_next;
  logic        kind, kind_next;
  logic [31:0] param, param_next;
  logic [15:0] code, code_next;
  logic [15:0] idle, idle_next;

  // Working values
  logic [15:0] p;
  logic [16:0] p_plus;
  logic [15:0] idx;
  logic [15:0] sum_add;
  logic [15:0] idle_inc;
  logic [7:0]  b;
  logic [7:0]  rs_hi, rs_lo, ds_hi, ds_lo, id_hi, id_lo;
  logic        fin;
  logic [2:0]  fin_status;

  assign b      = item.byte_value;
  assign p      = pos + 16'd1;
  assign p_plus = {1'b0, p} + 17'd1;
  assign idx    = p - 16'd5;
  assign sum_add  = sum + {8'h00, b};
  assign idle_inc = (idle == rpd_pkg::TICKS_MAX) ? idle : idle + 16'd1;
  assign rs_hi = regs.response_start_code[15:8];
  assign rs_lo = 8'(regs.response_start_code & rpd_pkg::LOW_BYTE_MASK);
  assign ds_hi = regs.data_start_code[15:8];
  assign ds_lo = 8'(regs.data_start_code & rpd_pkg::LOW_BYTE_MASK);
  assign id_hi = regs.device_id_code[15:8];
  assign id_lo = 8'(regs.device_id_code & rpd_pkg::LOW_BYTE_MASK);

  // Next state and result
  always_comb begin
    armed_next = armed;
    pos_next   = pos;
    len_next   = len;
    sum_next   = sum;
    kind_next  = kind;
    param_next = param;
    code_next  = code;
    idle_next  = idle;
    fin        = 1'b0;
    fin_status = rpd_pkg::STAT_OK;
    res_valid  = 1'b0;
    res        = '0;

    unique case (item.mode)
      rpd_pkg::MODE_ARM: begin
        armed_next = 1'b1;
        len_next   = (item.expected_length < rpd_pkg::MIN_LENGTH) ?
                     rpd_pkg::MIN_LENGTH : item.expected_length;
        pos_next   = '0;
        sum_next   = '0;
        kind_next  = rpd_pkg::PKT_RESPONSE;
        param_next = '0;
        code_next  = '0;
        idle_next  = '0;
      end
      rpd_pkg::MODE_BYTE: begin
        if (armed) begin
          idle_next = '0;
          pos_next  = p;
          if (p == 16'd1) begin
            // first start byte picks the packet kind
            sum_next = sum_add;
            if (b == rs_hi) begin
              kind_next = rpd_pkg::PKT_RESPONSE;
            end else if (b == ds_hi) begin
              kind_next = rpd_pkg::PKT_DATA;
            end else begin
              fin = 1'b1;
              fin_status = rpd_pkg::STAT_BAD_START;
            end
          end else if (p == 16'd2) begin
            sum_next = sum_add;
            if (b == rs_lo) begin
              if (kind != rpd_pkg::PKT_RESPONSE) begin
                fin = 1'b1;
                fin_status = rpd_pkg::STAT_BAD_START;
              end
            end else if (b == ds_lo) begin
              if (kind != rpd_pkg::PKT_DATA) begin
                fin = 1'b1;
                fin_status = rpd_pkg::STAT_BAD_START;
              end
            end else begin
              fin = 1'b1;
              fin_status = rpd_pkg::STAT_BAD_START;
            end
          end else if (p == 16'd3 || p == 16'd4) begin
            sum_next = sum_add;
            if (b != ((p == 16'd3) ? id_hi : id_lo)) begin
              fin = 1'b1;
              fin_status = rpd_pkg::STAT_BAD_ID;
            end
          end else if (p_plus < {1'b0, len}) begin
            // payload byte
            sum_next = sum_add;
            if (kind == rpd_pkg::PKT_DATA) begin
              res_valid        = 1'b1;
              res.result_kind  = rpd_pkg::RES_DATA;
              res.payload_byte = b;
              res.status       = rpd_pkg::STAT_OK;
              res.packet_kind  = rpd_pkg::PKT_DATA;
            end else if (idx < 16'd4) begin
              param_next = param | ({24'h000000, b} << {idx[1:0], 3'b000});
            end else if (idx == 16'd4) begin
              code_next = code | {8'h00, b};
            end else if (idx == 16'd5) begin
              code_next = code | {b, 8'h00};
            end
          end else if (p_plus == {1'b0, len}) begin
            // trailer low byte
            if (b != sum[7:0]) begin
              fin = 1'b1;
              fin_status = rpd_pkg::STAT_BAD_SUM;
            end
          end else begin
            // trailer high byte closes the read
            fin = 1'b1;
            fin_status = (b != sum[15:8]) ? rpd_pkg::STAT_BAD_SUM : rpd_pkg::STAT_OK;
          end
        end
      end
      rpd_pkg::MODE_TICK: begin
        if (armed) begin
          idle_next = idle_inc;
          if (idle_inc >= regs.timeout_ticks) begin
            fin = 1'b1;
            fin_status = rpd_pkg::STAT_TIMEOUT;
          end
        end
      end
      default: ;
    endcase

    // End of read
    if (fin) begin
      armed_next      = 1'b0;
      res_valid       = 1'b1;
      res.result_kind = rpd_pkg::RES_END;
      res.status      = fin_status;
      res.packet_kind = kind;
      if (fin_status == rpd_pkg::STAT_OK && kind == rpd_pkg::PKT_RESPONSE) begin
        res.parameter_word = param;
        res.response_code  = code;
      end
    end
  end

  // State update on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      pos   <= '0;
      len   <= '0;
      sum   <= '0;
      kind  <= 1'b0;
      param <= '0;
      code  <= '0;
      idle  <= '0;
    end else if (fire) begin
      armed <= armed_next;
      pos   <= pos_next;
      len   <= len_next;
      sum   <= sum_next;
      kind  <= kind_next;
      param <= param_next;
      code  <= code_next;
      idle  <= idle_next;
    end
  end

endmodule

[rtl/core/response_packet_deframer.sv]
// Response packet deframer. Each request (arm, received byte or time tick)
// is captured in an input register, processed combinationally by the engine
// against the read state, and any result lands in an output register; one
// request is taken every clock while results drain.
module response_packet_deframer (
  input  logic       clk,
  input  logic       rst,
  rpd_in_if.sink     item_in,
  rpd_out_if.source  result_out,
  rpd_cfg_if.sink    cfg
);

  rpd_pkg::cfg_t    regs;
  rpd_pkg::item_t   in_q;
  logic             in_q_valid;
  rpd_pkg::result_t out_q;
  logic             out_valid;
  logic             advance;
  logic             eng_res_valid;
  rpd_pkg::result_t eng_res;

  rpd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Pipeline handshake
  assign advance       = in_q_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !in_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_q.mode            <= item_in.mode;
      in_q.byte_value      <= item_in.byte_value;
      in_q.expected_length <= item_in.expected_length;
    end
  end

  rpd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (in_q),
    .regs      (regs),
    .res_valid (eng_res_valid),
    .res       (eng_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && eng_res_valid) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eng_res_valid) begin
      out_q <= eng_res;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.result_kind    = out_q.result_kind;
  assign result_out.payload_byte   = out_q.payload_byte;
  assign result_out.status         = out_q.status;
  assign result_out.packet_kind    = out_q.packet_kind;
  assign result_out.parameter_word = out_q.parameter_word;
  assign result_out.response_code  = out_q.response_code;

  // A new result only appears after the engine processed a request
  a_result_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && eng_res_valid))
    else $error("result appeared without a processed request");

  // A held request is kept while the output side is stalled
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && out_valid && !result_out.ready) |=> in_q_valid)
    else $error("pending request lost during output stall");

  // Payload bytes only come from data packets and carry no status
  a_data_byte_kind: assert property (@(posedge clk) disable iff (rst)
    (eng_res_valid && eng_res.result_kind == rpd_pkg::RES_DATA) |->
      (eng_res.packet_kind == rpd_pkg::PKT_DATA && eng_res.status == rpd_pkg::STAT_OK))
    else $error("payload byte result from a non-data packet");

endmodule

[test/response_packet_deframer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for response_packet_deframer: directed and random packet reads
// across several register settings, checked by a scoreboard class. Depends on rpd_pkg,
// the rpd_in_if / rpd_out_if / rpd_cfg_if interfaces and the deframer itself.
module response_packet_deframer_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {
    FLAW_NONE, FLAW_START_HI, FLAW_START_LO, FLAW_ID, FLAW_SUM,
    FLAW_CUT, FLAW_LENGTH, FLAW_TIMEOUT
  } read_flaw_t;

  // Scoreboard: tracks the read state per request and holds the expected results
  class deframer_scoreboard_t;
    rpd_pkg::cfg_t    regs;
    bit               armed;
    logic [15:0]      bytes_read;
    logic [15:0]      length_goal;
    logic [15:0]      byte_sum;
    logic             kind_now;
    logic [31:0]      param_acc;
    logic [15:0]      code_acc;
    logic [15:0]      ticks_idle;
    rpd_pkg::result_t pending_results[$];
    int               failures;
    int               data_seen;
    int               ends_seen;
    int               status_seen[5];

    function new();
      regs.response_start_code = rpd_pkg::RST_RESPONSE_START;
      regs.data_start_code     = rpd_pkg::RST_DATA_START;
      regs.device_id_code      = rpd_pkg::RST_DEVICE_ID;
      regs.timeout_ticks       = rpd_pkg::RST_TIMEOUT;
      armed       = 1'b0;
      bytes_read  = '0;
      length_goal = '0;
      byte_sum    = '0;
      kind_now    = rpd_pkg::PKT_RESPONSE;
      param_acc   = '0;
      code_acc    = '0;
      ticks_idle  = '0;
      failures    = 0;
      data_seen   = 0;
      ends_seen   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        rpd_pkg::CFG_RESPONSE_START: regs.response_start_code = value;
        rpd_pkg::CFG_DATA_START:     regs.data_start_code = value;
        rpd_pkg::CFG_DEVICE_ID:      regs.device_id_code = value;
        rpd_pkg::CFG_TIMEOUT:        regs.timeout_ticks = value;
        default: ;
      endcase
    endfunction

    // Close the read with a status word
    function void end_read(logic [2:0] st);
      rpd_pkg::result_t r;
      bit               full;
      full = (st == rpd_pkg::STAT_OK && kind_now == rpd_pkg::PKT_RESPONSE);
      r.result_kind    = rpd_pkg::RES_END;
      r.payload_byte   = '0;
      r.status         = st;
      r.packet_kind    = kind_now;
      r.parameter_word = full ? param_acc : '0;
      r.response_code  = full ? code_acc : '0;
      pending_results.push_back(r);
      armed = 1'b0;
    endfunction

    // Advance the read state for one accepted request
    function void absorb_request(rpd_pkg::item_t req);
      logic [7:0]       b;
      int               pos;
      int               idx;
      rpd_pkg::result_t r;
      b = req.byte_value;
      case (req.mode)
        rpd_pkg::MODE_ARM: begin
          armed       = 1'b1;
          length_goal = (req.expected_length < rpd_pkg::MIN_LENGTH) ?
                        rpd_pkg::MIN_LENGTH : req.expected_length;
          bytes_read  = '0;
          byte_sum    = '0;
          kind_now    = rpd_pkg::PKT_RESPONSE;
          param_acc   = '0;
          code_acc    = '0;
          ticks_idle  = '0;
        end
        rpd_pkg::MODE_BYTE: if (armed) begin
          ticks_idle = '0;
          bytes_read = bytes_read + 16'd1;
          pos = int'(bytes_read);
          if (pos == 1) begin
            byte_sum = byte_sum + 16'(b);
            if (b == regs.response_start_code[15:8]) kind_now = rpd_pkg::PKT_RESPONSE;
            else if (b == regs.data_start_code[15:8]) kind_now = rpd_pkg::PKT_DATA;
            else end_read(rpd_pkg::STAT_BAD_START);
          end else if (pos == 2) begin
            byte_sum = byte_sum + 16'(b);
            if (b == regs.response_start_code[7:0]) begin
              if (kind_now != rpd_pkg::PKT_RESPONSE) end_read(rpd_pkg::STAT_BAD_START);
            end else if (b == regs.data_start_code[7:0]) begin
              if (kind_now != rpd_pkg::PKT_DATA) end_read(rpd_pkg::STAT_BAD_START);
            end else begin
              end_read(rpd_pkg::STAT_BAD_START);
            end
          end else if (pos == 3) begin
            byte_sum = byte_sum + 16'(b);
            if (b != regs.device_id_code[15:8]) end_read(rpd_pkg::STAT_BAD_ID);
          end else if (pos == 4) begin
            byte_sum = byte_sum + 16'(b);
            if (b != regs.device_id_code[7:0]) end_read(rpd_pkg::STAT_BAD_ID);
          end else if (pos + 1 < int'(length_goal)) begin
            // payload
            byte_sum = byte_sum + 16'(b);
            idx = pos - 5;
            if (kind_now == rpd_pkg::PKT_DATA) begin
              r.result_kind    = rpd_pkg::RES_DATA;
              r.payload_byte   = b;
              r.status         = rpd_pkg::STAT_OK;
              r.packet_kind    = rpd_pkg::PKT_DATA;
              r.parameter_word = '0;
              r.response_code  = '0;
              pending_results.push_back(r);
            end else if (idx < 4) begin
              param_acc = param_acc | (32'(b) << (8 * idx));
            end else if (idx < 6) begin
              code_acc = code_acc | (16'(b) << (8 * (idx - 4)));
            end
          end else if (pos + 1 == int'(length_goal)) begin
            if (b != byte_sum[7:0]) end_read(rpd_pkg::STAT_BAD_SUM);
          end else begin
            if (b != byte_sum[15:8]) end_read(rpd_pkg::STAT_BAD_SUM);
            else end_read(rpd_pkg::STAT_OK);
          end
        end
        rpd_pkg::MODE_TICK: if (armed) begin
          if (ticks_idle != rpd_pkg::TICKS_MAX) ticks_idle = ticks_idle + 16'd1;
          if (ticks_idle >= regs.timeout_ticks) end_read(rpd_pkg::STAT_TIMEOUT);
        end
        default: ;
      endcase
    endfunction

    function string describe(rpd_pkg::result_t r);
      return $sformatf("kind=%0d byte=%02h status=%0d packet=%0d param=%08h code=%04h",
                       r.result_kind, r.payload_byte, r.status, r.packet_kind,
                       r.parameter_word, r.response_code);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(rpd_pkg::result_t got);
      rpd_pkg::result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) $display("unexpected result: %s", describe(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind || got.payload_byte !== want.payload_byte ||
          got.status !== want.status || got.packet_kind !== want.packet_kind ||
          got.parameter_word !== want.parameter_word ||
          got.response_code !== want.response_code) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch: expected %s / actual %s", describe(want), describe(got));
      end else if (want.result_kind == rpd_pkg::RES_DATA) begin
        data_seen++;
      end else begin
        ends_seen++;
        status_seen[want.status]++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rpd_in_if  item_if();
  rpd_out_if res_if();
  rpd_cfg_if cfg_if();

  response_packet_deframer DUT (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (res_if),
    .cfg        (cfg_if)
  );

  deframer_scoreboard_t sb;
  bit          calm;
  int          items_sent;
  int          settings_used;
  int          cycle_count;
  logic [15:0] cur_resp;
  logic [15:0] cur_data;
  logic [15:0] cur_dev;
  logic [15:0] cur_tmo;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    rpd_pkg::result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.result_kind    = res_if.result_kind;
      got.payload_byte   = res_if.payload_byte;
      got.status         = res_if.status;
      got.packet_kind    = res_if.packet_kind;
      got.parameter_word = res_if.parameter_word;
      got.response_code  = res_if.response_code;
      sb.check_result(got);
    end
  end

  // Receiver backpressure in random bursts
  initial begin
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        res_if.ready <= 1'b1;
      end
    end
  end

  // Drive one request and wait until it is taken
  task automatic send_item(input logic [1:0] mode, input logic [7:0] b,
                           input logic [15:0] len, input bit counted);
    rpd_pkg::item_t req;
    req.mode = mode;
    req.byte_value = b;
    req.expected_length = len;
    if (!calm && $urandom_range(0, 7) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_if.valid           <= 1'b1;
    item_if.mode            <= mode;
    item_if.byte_value      <= b;
    item_if.expected_length <= len;
    do @(posedge clk); while (!item_if.ready);
    sb.absorb_request(req);
    if (counted) items_sent++;
  endtask

  // Hold off the sender until every expected result is in, then let the pipe settle
  task automatic wait_for_results();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, value);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One framed read: arm, header, payload, little-endian sum, with an optional flaw.
  // A negative arm_len_req picks the arm length here.
  task automatic drive_read(input bit as_data, input int n_payload,
                            input read_flaw_t flaw, input int arm_len_req);
    logic [7:0]  frame[$];
    logic [15:0] sum;
    logic [15:0] start;
    logic [15:0] arm_len;
    int          quiet;
    int          stall_at;
    int          cut_at;
    start = as_data ? cur_data : cur_resp;
    frame = {start[15:8], start[7:0], cur_dev[15:8], cur_dev[7:0]};
    repeat (n_payload) frame.push_back(8'($urandom_range(0, 255)));
    case (flaw)
      FLAW_START_HI: frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
      FLAW_START_LO: frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
      FLAW_ID: begin
        stall_at = 2 + $urandom_range(0, 1);
        frame[stall_at] = frame[stall_at] ^ 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    sum = '0;
    foreach (frame[i]) sum = sum + 16'(frame[i]);
    frame.push_back(sum[7:0]);
    frame.push_back(sum[15:8]);
    if (flaw == FLAW_SUM) begin
      stall_at = frame.size() - 1 - $urandom_range(0, 1);
      frame[stall_at] = frame[stall_at] ^ 8'($urandom_range(1, 255));
    end

    arm_len = 16'(frame.size());
    if (arm_len_req >= 0) arm_len = 16'(arm_len_req);
    else if (flaw == FLAW_LENGTH) arm_len = 16'($urandom_range(0, 65535));
    else if (n_payload == 0 && $urandom_range(0, 1) == 0) arm_len = 16'($urandom_range(0, 5));

    quiet    = (cur_tmo == 0) ? 0 : ((cur_tmo > 4) ? 3 : int'(cur_tmo) - 1);
    stall_at = (flaw == FLAW_TIMEOUT) ? $urandom_range(0, frame.size() - 1) : -1;
    cut_at   = (flaw == FLAW_CUT) ? $urandom_range(1, frame.size() - 1) : frame.size();

    send_item(rpd_pkg::MODE_ARM, 8'($urandom_range(0, 255)), arm_len, 1'b1);
    for (int i = 0; i < cut_at; i++) begin
      if (i == stall_at) begin
        repeat ((cur_tmo == 0) ? 1 : int'(cur_tmo))
          send_item(rpd_pkg::MODE_TICK, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 1'b1);
      end else if (quiet > 0 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, quiet))
          send_item(rpd_pkg::MODE_TICK, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 1'b1);
      end
      send_item(rpd_pkg::MODE_BYTE, frame[i], 16'($urandom_range(0, 65535)), 1'b1);
    end
  endtask

  // Program a register setting, then run random reads until the item goal is met
  task automatic run_phase(input logic [15:0] resp, input logic [15:0] data,
                           input logic [15:0] dev, input logic [15:0] tmo,
                           input int goal, input bit quiet_run);
    int         r;
    int         n_payload;
    read_flaw_t flaw;
    logic [1:0] noise_mode;
    wait_for_results();
    calm = quiet_run;
    write_reg(rpd_pkg::CFG_RESPONSE_START, resp);
    write_reg(rpd_pkg::CFG_DATA_START, data);
    write_reg(rpd_pkg::CFG_DEVICE_ID, dev);
    write_reg(rpd_pkg::CFG_TIMEOUT, tmo);
    cur_resp = resp;
    cur_data = data;
    cur_dev  = dev;
    cur_tmo  = tmo;
    settings_used++;
    goal = goal + items_sent;
    while (items_sent < goal) begin
      n_payload = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      r = $urandom_range(0, 99);
      if (r < 60) flaw = FLAW_NONE;
      else if (r < 66) flaw = FLAW_START_HI;
      else if (r < 72) flaw = FLAW_START_LO;
      else if (r < 78) flaw = FLAW_ID;
      else if (r < 85) flaw = FLAW_SUM;
      else if (r < 90) flaw = FLAW_CUT;
      else if (r < 95) flaw = FLAW_LENGTH;
      else flaw = (cur_tmo <= 16'd64) ? FLAW_TIMEOUT : FLAW_NONE;
      drive_read(1'($urandom_range(0, 1)), n_payload, flaw, -1);
      // line noise between reads, mostly seen while unarmed
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(0, 2);
          noise_mode = (r == 0) ? rpd_pkg::MODE_BYTE :
                       ((r == 1) ? rpd_pkg::MODE_TICK : MODE_UNUSED);
          send_item(noise_mode, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 1'b0);
        end
      end
      if (!calm && $urandom_range(0, 24) == 0) wait_for_results();
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    calm = 1'b0;
    items_sent = 0;
    settings_used = 1;
    cur_resp = rpd_pkg::RST_RESPONSE_START;
    cur_data = rpd_pkg::RST_DATA_START;
    cur_dev  = rpd_pkg::RST_DEVICE_ID;
    cur_tmo  = rpd_pkg::RST_TIMEOUT;
    rst <= 1'b1;
    item_if.valid           <= 1'b0;
    item_if.mode            <= rpd_pkg::MODE_TICK;
    item_if.byte_value      <= '0;
    item_if.expected_length <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= rpd_pkg::CFG_RESPONSE_START;
    cfg_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored requests while unarmed, rearm, short length, short and data reads
    send_item(rpd_pkg::MODE_BYTE, 8'hFF, 16'hFFFF, 1'b1);
    send_item(rpd_pkg::MODE_TICK, 8'h00, 16'h0000, 1'b1);
    send_item(MODE_UNUSED, 8'hA5, 16'h5A5A, 1'b1);
    send_item(rpd_pkg::MODE_ARM, 8'h00, 16'hFFFF, 1'b1);
    send_item(rpd_pkg::MODE_BYTE, rpd_pkg::RST_RESPONSE_START[15:8], 16'h0000, 1'b1);
    drive_read(1'b0, 0, FLAW_NONE, 0);
    drive_read(1'b1, 1, FLAW_NONE, -1);

    // Random reads over several register settings
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'd4, 170, 1'b0);
    // both start codes share their first byte
    run_phase(16'h3C71, 16'h3C9E, 16'($urandom_range(0, 65535)), 16'd1, 110, 1'b0);
    // any tick ends the read
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'd0, 60, 1'b0);
    run_phase(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 130, 1'b0);
    run_phase(16'hFFFF, 16'h0000, 16'h0000, 16'd2, 130, 1'b0);
    run_phase(rpd_pkg::RST_RESPONSE_START, rpd_pkg::RST_DATA_START,
              rpd_pkg::RST_DEVICE_ID, 16'd6, 170, 1'b1);
    wait_for_results();

    if (sb.pending_results.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending_results.size());
      sb.failures++;
    end
    $display("Drove %0d requests over %0d register settings;", items_sent, settings_used);
    $display("checked %0d payload bytes and %0d reads", sb.data_seen, sb.ends_seen);
    $display("Read endings: ok %0d, timeout %0d, bad start %0d, bad id %0d, bad sum %0d",
             sb.status_seen[rpd_pkg::STAT_OK], sb.status_seen[rpd_pkg::STAT_TIMEOUT],
             sb.status_seen[rpd_pkg::STAT_BAD_START], sb.status_seen[rpd_pkg::STAT_BAD_ID],
             sb.status_seen[rpd_pkg::STAT_BAD_SUM]);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/rpd_pkg.sv
rtl/core/rpd_in_if.sv
rtl/core/rpd_out_if.sv
rtl/core/rpd_cfg_if.sv
rtl/core/rpd_cfg_regs.sv
rtl/core/rpd_engine.sv
rtl/core/response_packet_deframer.sv
test/response_packet_deframer_tb.sv
